// ===== rtl/graph_bfs_order_defines.svh =====
// assertion macros used by the checker file
`ifndef GRAPH_BFS_ORDER_DEFINES_SVH
`define GRAPH_BFS_ORDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GBFS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define GBFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define GBFS_ASSERT_RESET(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gbfs_pkg.sv =====
// shared types, constants and microcode table of the bfs order block
`default_nettype none

package gbfs_pkg;

   localparam int MAX_NODES = 64;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int PTR_W     = NODE_W + 1;
   localparam int ID_W      = 7;
   localparam int STEP_W    = 4;
   localparam int OP_W      = 4;
   localparam int COND_W    = 3;

   typedef struct packed {
      logic            command;
      logic [ID_W-1:0] edge_from;
      logic [ID_W-1:0] edge_to;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] visited_node;
      logic            last;
   } rsp_type;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
   localparam logic [OP_W-1:0] OP_ADDWR  = 4'd2;
   localparam logic [OP_W-1:0] OP_INIT   = 4'd3;
   localparam logic [OP_W-1:0] OP_QRD    = 4'd4;
   localparam logic [OP_W-1:0] OP_ROWRD  = 4'd5;
   localparam logic [OP_W-1:0] OP_FRESH  = 4'd6;
   localparam logic [OP_W-1:0] OP_SCAN   = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT   = 4'd8;

   localparam logic [COND_W-1:0] C_NEXT  = 3'd0;
   localparam logic [COND_W-1:0] C_JUMP  = 3'd1;
   localparam logic [COND_W-1:0] C_RUN   = 3'd2;
   localparam logic [COND_W-1:0] C_FRESH = 3'd3;
   localparam logic [COND_W-1:0] C_MORE  = 3'd4;

   localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] S_ADDWR = 4'd1;
   localparam logic [STEP_W-1:0] S_INIT  = 4'd2;
   localparam logic [STEP_W-1:0] S_QRD   = 4'd3;
   localparam logic [STEP_W-1:0] S_ROWRD = 4'd4;
   localparam logic [STEP_W-1:0] S_FRESH = 4'd5;
   localparam logic [STEP_W-1:0] S_SCAN  = 4'd6;
   localparam logic [STEP_W-1:0] S_EMIT  = 4'd7;
   localparam logic [STEP_W-1:0] S_DONE  = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   function automatic ctrl_type gbfs_rom(input logic [STEP_W-1:0] step);
      ctrl_type cw;
      unique case (step)
         S_IDLE:  cw = '{op: OP_ACCEPT, cond: C_RUN,   target: S_INIT};
         S_ADDWR: cw = '{op: OP_ADDWR,  cond: C_JUMP,  target: S_IDLE};
         S_INIT:  cw = '{op: OP_INIT,   cond: C_NEXT,  target: S_IDLE};
         S_QRD:   cw = '{op: OP_QRD,    cond: C_NEXT,  target: S_IDLE};
         S_ROWRD: cw = '{op: OP_ROWRD,  cond: C_NEXT,  target: S_IDLE};
         S_FRESH: cw = '{op: OP_FRESH,  cond: C_NEXT,  target: S_IDLE};
         S_SCAN:  cw = '{op: OP_SCAN,   cond: C_FRESH, target: S_SCAN};
         S_EMIT:  cw = '{op: OP_EMIT,   cond: C_MORE,  target: S_QRD};
         S_DONE:  cw = '{op: OP_NOP,    cond: C_JUMP,  target: S_IDLE};
         default: cw = '{op: OP_NOP,    cond: C_JUMP,  target: S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/graph_bfs_order.sv =====
// edge add: bound by the read-modify-write of one adjacency row
// run: its length grows with each visited node and its newly queued neighbors, plus output stalls
// one item at a time; a run is paced by the single read port of the adjacency ram
// reset clears row valid flags at once, so no clearing pass; node_count resets to 64
// visited set, queue pointers and sequencer step return to zero on reset
`default_nettype none

module graph_bfs_order
   import gbfs_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_type         req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_type              rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [ID_W-1:0] csr_wr_data
);

   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ID_W-1:0]      node_count_ff, node_count_in;
   logic [MAX_NODES-1:0] row_valid_ff, row_valid_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 edge_ok_ff, edge_ok_in;
   logic [NODE_W-1:0]    from_idx_ff, from_idx_in;
   logic [NODE_W-1:0]    to_idx_ff, to_idx_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] fresh_ff, fresh_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;

   ctrl_type             ctrl;
   logic                 req_accept;
   logic                 out_busy;
   logic                 hold;
   logic                 cond_true;
   logic [ID_W-1:0]      eff_count;
   logic [MAX_NODES-1:0] count_mask;
   logic [MAX_NODES-1:0] adj_row;
   logic [MAX_NODES-1:0] low_bit;
   logic [NODE_W-1:0]    low_idx;
   logic [ID_W-1:0]      from_m1;
   logic [ID_W-1:0]      to_m1;

   logic                 adj_we;
   logic [NODE_W-1:0]    adj_rd_addr;
   logic [MAX_NODES-1:0] adj_wr_data;
   logic [MAX_NODES-1:0] adj_rd_data;
   logic                 q_we;
   logic [NODE_W-1:0]    q_wr_addr;
   logic [NODE_W-1:0]    q_wr_data;
   logic [NODE_W-1:0]    q_rd_addr;
   logic [NODE_W-1:0]    q_rd_data;

   assign ctrl       = gbfs_rom(step_ff);
   assign req_stall  = (ctrl.op != OP_ACCEPT);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // effective node count and its id mask
   always_comb begin
      if (node_count_ff == '0) begin
         eff_count = ID_W'(1);
      end else if (node_count_ff > ID_W'(MAX_NODES)) begin
         eff_count = ID_W'(MAX_NODES);
      end else begin
         eff_count = node_count_ff;
      end
      for (int b = 0; b < MAX_NODES; b++) begin
         count_mask[b] = (ID_W'(b) < eff_count);
      end
   end

   assign adj_row = rd_valid_ff ? adj_rd_data : '0;

   // lowest pending neighbor
   always_comb begin
      low_bit = fresh_ff & (~fresh_ff + MAX_NODES'(1));
      low_idx = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | NODE_W'(i);
         end
      end
   end

   assign from_m1 = req_payload.edge_from - ID_W'(1);
   assign to_m1   = req_payload.edge_to - ID_W'(1);

   // sequencing
   always_comb begin
      hold = ((ctrl.op == OP_ACCEPT) && !req_valid) || ((ctrl.op == OP_EMIT) && out_busy);
      case (ctrl.cond)
         C_NEXT:  cond_true = 1'b0;
         C_JUMP:  cond_true = 1'b1;
         C_RUN:   cond_true = (req_payload.command == CMD_RUN);
         C_FRESH: cond_true = (fresh_ff != '0);
         C_MORE:  cond_true = (head_ff < tail_ff);
         default: cond_true = 1'b0;
      endcase
      if (hold) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // datapath
   always_comb begin
      node_count_in  = csr_wr_en ? csr_wr_data : node_count_ff;
      row_valid_in   = row_valid_ff;
      edge_ok_in     = edge_ok_ff;
      from_idx_in    = from_idx_ff;
      to_idx_in      = to_idx_ff;
      visited_in     = visited_ff;
      fresh_in       = fresh_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      node_in        = node_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      adj_we         = 1'b0;
      adj_rd_addr    = from_m1[NODE_W-1:0];
      adj_wr_data    = adj_row;
      q_we           = 1'b0;
      q_wr_addr      = tail_ff[NODE_W-1:0];
      q_wr_data      = low_idx;
      q_rd_addr      = head_ff[NODE_W-1:0];

      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_ACCEPT: begin
            if (req_accept) begin
               edge_ok_in  = (req_payload.edge_from != '0) &&
                             (req_payload.edge_from <= eff_count) &&
                             (req_payload.edge_to != '0) &&
                             (req_payload.edge_to <= eff_count);
               from_idx_in = from_m1[NODE_W-1:0];
               to_idx_in   = to_m1[NODE_W-1:0];
            end
         end
         OP_ADDWR: begin
            adj_we      = edge_ok_ff;
            adj_wr_data = adj_row | (MAX_NODES'(1) << to_idx_ff);
            if (edge_ok_ff) begin
               row_valid_in[from_idx_ff] = 1'b1;
            end
         end
         OP_INIT: begin
            visited_in = MAX_NODES'(1);
            head_in    = '0;
            tail_in    = PTR_W'(1);
            q_we       = 1'b1;
            q_wr_addr  = '0;
            q_wr_data  = '0;
         end
         OP_QRD: begin
            head_in = head_ff + PTR_W'(1);
         end
         OP_ROWRD: begin
            adj_rd_addr = q_rd_data;
            node_in     = q_rd_data;
         end
         OP_FRESH: begin
            fresh_in = adj_row & ~visited_ff & count_mask;
         end
         OP_SCAN: begin
            if (fresh_ff != '0) begin
               visited_in = visited_ff | low_bit;
               fresh_in   = fresh_ff & ~low_bit;
               if (tail_ff < PTR_W'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + PTR_W'(1);
               end
            end
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.visited_node = ID_W'(node_ff) + ID_W'(1);
               rsp_payload_in.last         = !(head_ff < tail_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_valid_in = row_valid_ff[adj_rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= S_IDLE;
         node_count_ff <= ID_W'(MAX_NODES);
         row_valid_ff  <= '0;
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         node_count_ff <= node_count_in;
         row_valid_ff  <= row_valid_in;
         visited_ff    <= visited_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff    <= rd_valid_in;
      edge_ok_ff     <= edge_ok_in;
      from_idx_ff    <= from_idx_in;
      to_idx_ff      <= to_idx_in;
      fresh_ff       <= fresh_in;
      node_ff        <= node_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // adjacency rows
   gbfs_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (from_idx_ff),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // node queue
   gbfs_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/gbfs_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/gbfs_checker.sv =====
// port-level checker for the bfs order block and its bind
`default_nettype none
`include "graph_bfs_order_defines.svh"

module gbfs_checker
   import gbfs_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_type         req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_type         rsp_payload,
   input wire logic            csr_wr_en,
   input wire logic [ID_W-1:0] csr_wr_data
);

   logic unused_ok;
   assign unused_ok = req_valid ^ (^req_payload) ^ csr_wr_en ^ (^csr_wr_data);

   `GBFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")
   `GBFS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "stalled result beat changed")
   `GBFS_ASSERT_NOW(a_run_busy, clock, reset, rsp_valid && !rsp_payload.last, req_stall, "input taken in the middle of a run")
   `GBFS_ASSERT_RESET(a_reset_quiet, clock, reset, !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind graph_bfs_order gbfs_checker u_gbfs_checker (.*);

`default_nettype wire

// ===== test/graph_bfs_order_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for graph_bfs_order: directed table, then random graphs and runs
module graph_bfs_order_test;
   import gbfs_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 100;
   localparam int SCRIPT_LEN    = 25;

   typedef enum logic [1:0] {ROW_ADD, ROW_RUN, ROW_CFG} row_kind_type;

   // first holds the source id or the node count, pin_node the single visit of a pinned run
   typedef struct packed {
      row_kind_type    kind;
      logic [ID_W-1:0] first;
      logic [ID_W-1:0] second;
      logic            pinned;
      logic [ID_W-1:0] pin_node;
   } script_row_type;

   script_row_type script [SCRIPT_LEN] = '{
      '{ROW_RUN, 7'd0,   7'd0,   1'b1, 7'd1},
      '{ROW_ADD, 7'd0,   7'd5,   1'b0, 7'd0},
      '{ROW_ADD, 7'd5,   7'd0,   1'b0, 7'd0},
      '{ROW_ADD, 7'd127, 7'd127, 1'b0, 7'd0},
      '{ROW_ADD, 7'd65,  7'd2,   1'b0, 7'd0},
      '{ROW_RUN, 7'd127, 7'd127, 1'b1, 7'd1},
      '{ROW_ADD, 7'd1,   7'd1,   1'b0, 7'd0},
      '{ROW_ADD, 7'd1,   7'd64,  1'b0, 7'd0},
      '{ROW_ADD, 7'd64,  7'd64,  1'b0, 7'd0},
      '{ROW_ADD, 7'd64,  7'd1,   1'b0, 7'd0},
      '{ROW_ADD, 7'd1,   7'd64,  1'b0, 7'd0},
      '{ROW_ADD, 7'd1,   7'd2,   1'b0, 7'd0},
      '{ROW_RUN, 7'd85,  7'd42,  1'b0, 7'd0},
      '{ROW_CFG, 7'd2,   7'd0,   1'b0, 7'd0},
      '{ROW_RUN, 7'd0,   7'd0,   1'b0, 7'd0},
      '{ROW_CFG, 7'd0,   7'd0,   1'b0, 7'd0},
      '{ROW_ADD, 7'd2,   7'd1,   1'b0, 7'd0},
      '{ROW_RUN, 7'd0,   7'd0,   1'b1, 7'd1},
      '{ROW_CFG, 7'd127, 7'd0,   1'b0, 7'd0},
      '{ROW_ADD, 7'd2,   7'd63,  1'b0, 7'd0},
      '{ROW_ADD, 7'd63,  7'd3,   1'b0, 7'd0},
      '{ROW_ADD, 7'd3,   7'd1,   1'b0, 7'd0},
      '{ROW_RUN, 7'd0,   7'd0,   1'b0, 7'd0},
      '{ROW_CFG, 7'd1,   7'd0,   1'b0, 7'd0},
      '{ROW_RUN, 7'd42,  7'd85,  1'b1, 7'd1}
   };

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_type         req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_type         rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic [ID_W-1:0] csr_wr_data = '0;

   // travels with the payload: the run's only visit is typed in the table
   logic            row_pinned  = 1'b0;
   logic [ID_W-1:0] pin_node    = '0;

   logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
   logic [ID_W-1:0]      count_reg = 7'd64;
   rsp_type              walk [$];
   rsp_type              visits_due [$];

   bit          calm_phase  = 1'b0;
   bit          hold_ask    = 1'b0;
   bit          hold_active = 1'b0;
   bit          hold_done   = 1'b0;
   int unsigned errors        = 0;
   int unsigned beats_in      = 0;
   int unsigned runs_in       = 0;
   int unsigned visits_seen   = 0;
   int unsigned settings_made = 0;

   graph_bfs_order dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
   end

   function automatic int unsigned node_limit(input logic [ID_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_NODES) return MAX_NODES;
      return count;
   endfunction

   // updates the adjacency copy on an add, fills walk with the visit order on a run
   function automatic void bfs_visit_order(input req_type beat);
      int unsigned          lim;
      int unsigned          head;
      int unsigned          tail;
      logic [MAX_NODES-1:0] seen;
      logic [MAX_NODES-1:0] fresh;
      logic [MAX_NODES-1:0] in_range;
      logic [5:0]           fifo [MAX_NODES];
      rsp_type              visit;
      walk.delete();
      lim = node_limit(count_reg);
      if (beat.command == CMD_ADD) begin
         if (beat.edge_from >= 1 && beat.edge_from <= lim &&
             beat.edge_to >= 1 && beat.edge_to <= lim)
            adj_rows[beat.edge_from - 1][beat.edge_to - 1] = 1'b1;
         return;
      end
      in_range = (lim >= MAX_NODES) ? '1 : ((64'd1 << lim) - 64'd1);
      seen = 64'd1;
      fifo[0] = '0;
      head = 0;
      tail = 1;
      while (head < tail) begin
         visit.visited_node = ID_W'(fifo[head]) + ID_W'(1);
         visit.last = 1'b0;
         walk = {walk, visit};
         fresh = adj_rows[fifo[head]] & ~seen & in_range;
         head++;
         for (int b = 0; b < MAX_NODES; b++) begin
            if (fresh[b]) begin
               seen[b] = 1'b1;
               fifo[tail] = 6'(b);
               tail++;
            end
         end
      end
      walk[walk.size() - 1].last = 1'b1;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [ID_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 7'd0;
      if (roll == 1) return 7'd127;
      if (roll == 2) return 7'd64;
      if (roll == 3) return ID_W'($urandom_range(65, 127));
      if (roll < 6) return ID_W'($urandom_range(9, 63));
      return ID_W'($urandom_range(1, 8));
   endfunction

   task automatic offer(input req_type beat, input logic pinned, input logic [ID_W-1:0] node);
      int unsigned gap;
      gap = idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      row_pinned  <= pinned;
      pin_node    <= node;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (visits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_node_count(input logic [ID_W-1:0] value);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            visits_seen++;
            if (visits_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected visit: expected none, got node %0d last %0b",
                        $time, rsp_payload.visited_node, rsp_payload.last);
            end else begin
               want = visits_due.pop_front();
               if (rsp_payload.visited_node !== want.visited_node ||
                   rsp_payload.last !== want.last) begin
                  errors++;
                  $display("%0t: visit mismatch: expected node %0d last %0b, got node %0d last %0b",
                           $time, want.visited_node, want.last,
                           rsp_payload.visited_node, rsp_payload.last);
               end
            end
         end
         if (csr_wr_en) begin
            count_reg = csr_wr_data;
            settings_made++;
         end
         if (req_valid && !req_stall) begin
            beats_in++;
            if (req_payload.command == CMD_RUN) runs_in++;
            bfs_visit_order(req_payload);
            if (row_pinned) begin
               want.visited_node = pin_node;
               want.last = 1'b1;
               visits_due = {visits_due, want};
            end else begin
               foreach (walk[i]) visits_due = {visits_due, walk[i]};
            end
         end
      end
   end

   // result side: random stalls, one long hold-off when the feed asks for it
   initial begin : drain_side
      int unsigned span;
      @(posedge clock);
      forever begin
         if (hold_ask && !hold_done) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            span = idle_span();
            rsp_stall <= (span != 0);
            repeat (span != 0 ? span : $urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin : feed_side
      script_row_type  row;
      req_type         beat;
      logic [ID_W-1:0] setting;
      int unsigned     counted;
      int unsigned     lim;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_CFG) begin
            set_node_count(row.first);
         end else begin
            beat.command   = (row.kind == ROW_RUN) ? CMD_RUN : CMD_ADD;
            beat.edge_from = row.first;
            beat.edge_to   = row.second;
            offer(beat, row.pinned, row.pin_node);
         end
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         setting = pick_count();
         set_node_count(setting);
         lim = node_limit(setting);
         calm_phase = ($urandom_range(0, 4) == 0);
         for (int burst = 0; burst < 2; burst++) begin
            repeat ($urandom_range(1, 10)) begin
               beat.command = CMD_ADD;
               if ($urandom_range(0, 6) == 0) begin
                  beat.edge_from = ID_W'($urandom_range(0, 127));
                  beat.edge_to   = ID_W'($urandom_range(0, 127));
               end else begin
                  beat.edge_from = ID_W'($urandom_range(0, 1) ? $urandom_range(1, lim)
                                         : $urandom_range(1, (lim < 6) ? lim : 6));
                  beat.edge_to   = ID_W'($urandom_range(1, lim));
               end
               offer(beat, 1'b0, '0);
               counted++;
            end
            // park the result side once, before the first random run, so the block backs up
            if (!hold_ask) begin
               req_valid <= 1'b0;
               hold_ask = 1'b1;
               @(posedge clock);
               while (!hold_active) @(posedge clock);
            end
            beat.command   = CMD_RUN;
            beat.edge_from = ID_W'($urandom_range(0, 127));
            beat.edge_to   = ID_W'($urandom_range(0, 127));
            offer(beat, 1'b0, '0);
            counted++;
         end
      end

      calm_phase = 1'b0;
      drain_all();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d beats in, %0d of them runs, over %0d node-count settings",
               beats_in, runs_in, settings_made);
      $display("checked %0d visits, %0d mismatches", visits_seen, errors);
      if (errors == 0 && visits_due.size() == 0) begin
         $display("** graph_bfs_order: PASSED **");
      end else begin
         $display("** graph_bfs_order: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout with %0d visits still due", $time, visits_due.size());
      $display("** graph_bfs_order: FAILED **");
      $finish;
   end

endmodule
